// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent true at one edge, consequent true at the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
// Antecedent and consequent checked at the same edge
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Constants, beat types, store and scan types and sequencer states of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Storage geometry
  localparam int unsigned WORD_COUNT = 32;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned OFS_W      = $clog2(WORD_BITS);
  localparam int unsigned WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  // Field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned SIZE_W = 11;

  // Size limits: storage and the 1024-position address space
  localparam int unsigned STORE_BITS = WORD_COUNT * WORD_BITS;
  localparam int unsigned SIZE_CAP   = (STORE_BITS < 1024) ? STORE_BITS : 1024;
  localparam int unsigned SIZE_RESET = 1024;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TEST       = 3'd0,
    CMD_SET        = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_FIND_SET   = 3'd3,
    CMD_FIND_CLEAR = 3'd4
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_e;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] bit_index;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic             bit_value;
    logic [POS_W-1:0] position;
    logic             found;
    logic             out_of_range;
  } out_item_t;

  // Bitmap store access
  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

  // Word scan request and result
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 want;
    logic [SIZE_W-1:0]    size;
    logic [SIZE_W-1:0]    base;
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic [OFS_W-1:0] offset;
    logic             last;
  } scan_res_t;

endpackage

// ===== rtl/core/bfa_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// bfa_bitmap_mem
// Bitmap word store: one write and one registered read port. Per-word valid
// flags cleared by reset make unwritten words read as zero.
// ----------------------------------------------------------------------------
module bfa_bitmap_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfa_pkg::mem_req_t             req,
  output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] vld_r;
  logic [WORD_BITS-1:0]  rd_word_r;
  logic                  rd_vld_r;

  // Written-word flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // Word array write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

// ===== rtl/core/bfa_word_scan.sv =====
// ----------------------------------------------------------------------------
// bfa_word_scan
// Shared scan unit: masks one word to the in-range positions, picks the
// lowest bit of the wanted value and flags the last word in range.
// ----------------------------------------------------------------------------
module bfa_word_scan (
  input  bfa_pkg::scan_req_t req,
  output bfa_pkg::scan_res_t res
);
  import bfa_pkg::*;

  logic [SIZE_W-1:0]    rem;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hits;
  logic [OFS_W-1:0]     ofs;

  // Positions left in range from this word's base
  assign rem  = req.size - req.base;
  assign cand = req.want ? req.word : ~req.word;

  // Range mask over the word
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (SIZE_W'(j) < rem);
    end
  end

  assign hits = cand & mask;

  // Lowest qualifying bit
  always_comb begin
    ofs = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hits[j]) begin
        ofs = OFS_W'(j);
      end
    end
  end

  assign res.hit    = |hits;
  assign res.offset = ofs;
  assign res.last   = (rem <= SIZE_W'(WORD_BITS));

endmodule

// ===== rtl/core/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Bitmap of used frames with test, set, clear, find-first-set and
// find-first-clear commands over the configured number of positions.
//
//   channel  direction  handshake          beat
//   in_      input      in_valid/in_ready  in_item_t  (command, bit_index)
//   out_     output     out_valid/out_ready out_item_t (bit_value, position,
//                                                        found, out_of_range)
//   cfg_     input      cfg_we             cfg_wdata  (bits_in_use)
//
// One command at a time. Test, set and clear: fetch, then modify, then done; an
// out-of-range index goes straight to done. Searches: fetch word 0, then scan one
// word per cycle (read port and scan unit) until a hit or the last word in range,
// passing at most 31 words before it, then done; straight to done at size zero.
// A finished result sits in the output register; the next command is taken
// while it waits. Reset (rst_n, synchronous) clears the bitmap at once through
// per-word valid flags and sets bits_in_use to 1024.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_frame_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bfa_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bfa_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bfa_pkg::out_item_t         out_data
);
  import bfa_pkg::*;

  state_e               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [POS_W-1:0]     idx_r, idx_nxt;
  logic [WORD_AW-1:0]   wrd_r, wrd_nxt;
  out_item_t            res_r, res_nxt;
  logic [SIZE_W-1:0]    size_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic                 out_load;

  logic [SIZE_W-1:0]    eff_size;
  logic [SIZE_W-1:0]    scan_base;
  logic                 is_search;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] bit_mask;
  mem_req_t             mem_req;
  scan_req_t            scan_req;
  scan_res_t            scan_res;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(SIZE_RESET);
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  assign eff_size  = (size_r > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : size_r;
  assign scan_base = SIZE_W'(wrd_r) << OFS_W;
  assign is_search = (cmd_r == CMD_FIND_SET) || (cmd_r == CMD_FIND_CLEAR);
  assign bit_mask  = WORD_BITS'(1) << idx_r[OFS_W-1:0];

  // Bitmap store and scan unit
  bfa_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign scan_req.word = rd_data;
  assign scan_req.want = (cmd_r == CMD_FIND_SET);
  assign scan_req.size = eff_size;
  assign scan_req.base = scan_base;

  bfa_word_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    wrd_r <= wrd_nxt;
    res_r <= res_nxt;
  end

  // Sequencer next state and store access
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    wrd_nxt   = wrd_r;
    res_nxt   = res_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          idx_nxt = in_data.bit_index;
          wrd_nxt = '0;
          res_nxt = '0;
          case (in_data.command)
            CMD_TEST, CMD_SET, CMD_CLEAR: begin
              if ({1'b0, in_data.bit_index} >= eff_size) begin
                res_nxt.out_of_range = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            CMD_FIND_SET, CMD_FIND_CLEAR: begin
              state_nxt = (eff_size == '0) ? S_DONE : S_FETCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FETCH: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = is_search ? '0 : WORD_AW'(idx_r[POS_W-1:OFS_W]);
        state_nxt       = is_search ? S_SCAN : S_MODIFY;
      end
      S_MODIFY: begin
        mem_req.wr_addr = WORD_AW'(idx_r[POS_W-1:OFS_W]);
        case (cmd_r)
          CMD_TEST: begin
            res_nxt.bit_value = rd_data[idx_r[OFS_W-1:0]];
          end
          CMD_SET: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data | bit_mask;
          end
          CMD_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data & ~bit_mask;
          end
          default: begin
          end
        endcase
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // One word per cycle; the next word is fetched while this one is tested
        if (scan_res.hit) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = POS_W'(scan_base + SIZE_W'(scan_res.offset));
          state_nxt        = S_DONE;
        end else if (scan_res.last) begin
          state_nxt = S_DONE;
        end else begin
          wrd_nxt         = wrd_r + WORD_AW'(1);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = wrd_nxt;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `ASSERT_SAME(a_scan_in_range, clk, rst_n, state_r == S_SCAN, scan_base < eff_size)
  `ASSERT_SAME(a_found_not_oor, clk, rst_n, out_valid_r, !(out_data_r.found && out_data_r.out_of_range))

endmodule
